FILE: rtl/assert_macros.svh
// Assertion helpers for the vertex transform checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define VTX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform check failed");

// Next-cycle implication, off while in reset.
`define VTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform check failed");

// Next-cycle implication, live through reset.
`define VTX_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vertex transform check failed");

`endif

FILE: rtl/vtx_pkg.sv
package vtx_pkg;

    localparam int DIM           = 4;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 2;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int SUM_W         = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_XFORM = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word t_row [DIM];

    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic signed [WORD_W-1:0] out_w;
    } t_result;

endpackage

FILE: rtl/vtx_in_if.sv
interface vtx_in_if;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [vtx_pkg::IDX_W-1:0] entry_row;
    logic [vtx_pkg::IDX_W-1:0] entry_col;
    vtx_pkg::t_word          entry_value;
    vtx_pkg::t_word          in_x;
    vtx_pkg::t_word          in_y;
    vtx_pkg::t_word          in_z;
    vtx_pkg::t_word          in_w;

    modport source (
        output valid, kind, entry_row, entry_col, entry_value, in_x, in_y, in_z, in_w,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_row, entry_col, entry_value, in_x, in_y, in_z, in_w,
        output ready
    );
endinterface

FILE: rtl/vtx_out_if.sv
interface vtx_out_if;
    logic           valid;
    logic           ready;
    vtx_pkg::t_word out_x;
    vtx_pkg::t_word out_y;
    vtx_pkg::t_word out_z;
    vtx_pkg::t_word out_w;

    modport source (output valid, out_x, out_y, out_z, out_w, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

FILE: rtl/vtx_lane.sv
module vtx_lane #(
    parameter int FRAC_BITS = vtx_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  vtx_pkg::t_row  i_coef,
    input  vtx_pkg::t_row  i_vec,
    output vtx_pkg::t_word o_res
);

    localparam int SUM_W  = vtx_pkg::SUM_W;
    localparam int WORD_W = vtx_pkg::WORD_W;
    localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'({1'b0, {(WORD_W-1){1'b1}}});
    localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'({1'b1, {(WORD_W-1){1'b0}}});

    logic signed [vtx_pkg::PROD_W-1:0] r_prod [vtx_pkg::DIM];
    logic signed [vtx_pkg::PAIR_W-1:0] r_s01;
    logic signed [vtx_pkg::PAIR_W-1:0] r_s23;
    logic signed [SUM_W-1:0]           r_sum;
    logic                              r_neg;
    logic                              r_over;
    logic [WORD_W-1:0]                 r_q;
    vtx_pkg::t_word                    r_res;

    logic [SUM_W-1:0]  n_mag;
    logic [SUM_W-1:0]  n_q;
    logic [SUM_W-1:0]  n_limit;
    logic [WORD_W-1:0] n_sat;
    vtx_pkg::t_word    n_res;

    always_comb begin
        n_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        n_q     = n_mag >> FRAC_BITS;
        n_limit = r_sum[SUM_W-1] ? NEG_LIMIT : POS_LIMIT;
        n_sat   = r_over ? (r_neg ? NEG_LIMIT[WORD_W-1:0] : POS_LIMIT[WORD_W-1:0]) : r_q;
        n_res   = r_neg ? vtx_pkg::t_word'(-n_sat) : vtx_pkg::t_word'(n_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < vtx_pkg::DIM; c++) begin
                r_prod[c] <= vtx_pkg::PROD_W'(i_coef[c]) * vtx_pkg::PROD_W'(i_vec[c]);
            end
            r_s01  <= vtx_pkg::PAIR_W'(r_prod[0]) + vtx_pkg::PAIR_W'(r_prod[1]);
            r_s23  <= vtx_pkg::PAIR_W'(r_prod[2]) + vtx_pkg::PAIR_W'(r_prod[3]);
            r_sum  <= SUM_W'(r_s01) + SUM_W'(r_s23);
            r_neg  <= r_sum[SUM_W-1];
            r_over <= n_q > n_limit;
            r_q    <= n_q[WORD_W-1:0];
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/vtx_merge.sv
module vtx_merge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_up_valid,
    input  vtx_pkg::t_row    i_lane_res,
    output logic             o_up_ready,
    vtx_out_if.source        o_out
);

    vtx_pkg::t_result n_up;
    vtx_pkg::t_result r_out;
    vtx_pkg::t_result r_hold;
    logic             r_out_valid;
    logic             r_hold_valid;

    always_comb begin
        n_up.out_x = i_lane_res[0];
        n_up.out_y = i_lane_res[1];
        n_up.out_z = i_lane_res[2];
        n_up.out_w = i_lane_res[3];
    end

    assign o_up_ready = !r_hold_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_hold_valid) begin
                r_out_valid  <= 1'b1;
                r_hold_valid <= 1'b0;
            end else begin
                r_out_valid <= i_up_valid;
            end
        end else if (i_up_valid && !r_hold_valid) begin
            r_hold_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            r_out <= r_hold_valid ? r_hold : n_up;
        end else if (!r_hold_valid) begin
            r_hold <= n_up;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_x = r_out.out_x;
    assign o_out.out_y = r_out.out_y;
    assign o_out.out_z = r_out.out_z;
    assign o_out.out_w = r_out.out_w;

endmodule

FILE: rtl/vertex_transform_4x4_top.sv
// Transforms pass the lane and merge registers. Throughput: one transaction per cycle
// while ready is high; four row lanes, each with four multipliers, run side by side, and
// a two-entry output skid parts the two handshakes.
// Load transactions write the matrix at acceptance and give no output.
// Reset (synchronous, active low) restores the identity matrix and empties the pipeline.
module vertex_transform_4x4_top #(
    parameter int FRAC_BITS = vtx_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vtx_in_if.sink    i_in,
    vtx_out_if.source o_out
);

    localparam int NSTAGE = 5;

    vtx_pkg::t_word r_mat [vtx_pkg::DIM][vtx_pkg::DIM];
    logic [NSTAGE-1:0] r_vld;
    logic              w_en;
    logic              w_accept;
    vtx_pkg::t_row     w_vec;
    vtx_pkg::t_row     w_lane_res;

    assign w_accept = i_in.valid && w_en;
    assign i_in.ready = w_en;

    assign w_vec[0] = i_in.in_x;
    assign w_vec[1] = i_in.in_y;
    assign w_vec[2] = i_in.in_z;
    assign w_vec[3] = i_in.in_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < vtx_pkg::DIM; r++) begin
                for (int c = 0; c < vtx_pkg::DIM; c++) begin
                    r_mat[r][c] <= (r == c) ? vtx_pkg::t_word'(1 << FRAC_BITS) : '0;
                end
            end
        end else if (w_accept && (i_in.kind == vtx_pkg::KIND_LOAD)) begin
            r_mat[i_in.entry_row][i_in.entry_col] <= i_in.entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-2:0], w_accept && (i_in.kind == vtx_pkg::KIND_XFORM)};
        end
    end

    for (genvar g = 0; g < vtx_pkg::DIM; g++) begin : g_lane
        vtx_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_coef (r_mat[g]),
            .i_vec  (w_vec),
            .o_res  (w_lane_res[g])
        );
    end

    vtx_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (r_vld[NSTAGE-1]),
        .i_lane_res (w_lane_res),
        .o_up_ready (w_en),
        .o_out      (o_out)
    );

endmodule

FILE: rtl/vtx_checker.sv
`include "assert_macros.svh"

module vtx_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input vtx_pkg::t_word i_out_x,
    input vtx_pkg::t_word i_out_y,
    input vtx_pkg::t_word i_out_z,
    input vtx_pkg::t_word i_out_w
);

    logic                          w_stall;
    logic [4*vtx_pkg::WORD_W-1:0]  w_out_all;

    assign w_stall   = i_out_valid && !i_out_ready;
    assign w_out_all = {i_out_x, i_out_y, i_out_z, i_out_w};

    `VTX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid)
    `VTX_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable(w_out_all))
    `VTX_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid && i_in_ready)
    `VTX_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `VTX_ASSERT_NOW(a_ready_drop, i_clk, i_rst_n, $fell(i_in_ready), $past(w_stall))

endmodule

bind vertex_transform_4x4_top vtx_checker u_vtx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z),
    .i_out_w     (o_out.out_w)
);

FILE: test/tb_vertex_transform_4x4_top.sv
`timescale 1ns / 1ps

module tb_vertex_transform_4x4_top;
    import vtx_pkg::*;

    localparam int   FRAC        = FRAC_BITS_DEF;
    localparam int   N_RANDOM    = 1200;
    localparam int   STALL_LIMIT = 1000;
    localparam int   GAP_PCT     = 17;
    localparam t_word WORD_MAX   = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN   = 32'sh8000_0000;

    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        t_word            value;
        t_row             vtx;
    } t_vtx_txn;

    logic i_clk;
    logic i_rst_n;

    vtx_in_if  in_bus ();
    vtx_out_if out_bus ();

    vertex_transform_4x4_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_vtx_txn stim_q[$];
    t_result  vertex_q[$];
    t_word    matrix_words [DIM*DIM];
    t_vtx_txn nxt;
    t_result  got;
    t_result  want;
    logic     in_took;
    logic     gaps_off;
    int       n_in;
    int       n_errors;
    int       idle_cycles;

    assign gaps_off = (n_in >= 300) && (n_in < 600);

    function automatic t_word row_dot(input int row, input t_row v);
        logic signed [SUM_W-1:0] acc;
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] q;
        logic [SUM_W-1:0] lim;
        logic neg;
        acc = '0;
        for (int c = 0; c < DIM; c++) begin
            a = matrix_words[row*DIM + c];
            b = v[c];
            acc = acc + a * b;
        end
        neg = acc[SUM_W-1];
        mag = neg ? -acc : acc;
        q   = mag >> FRAC;
        lim = neg ? {{(SUM_W-WORD_W){1'b0}}, 32'h8000_0000}
                  : {{(SUM_W-WORD_W){1'b0}}, 32'h7FFF_FFFF};
        if (q > lim) begin
            q = lim;
        end
        return t_word'(neg ? -q : q);
    endfunction

    function automatic t_result transform_vertex(input t_row v);
        t_result r;
        r.out_x = row_dot(0, v);
        r.out_y = row_dot(1, v);
        r.out_z = row_dot(2, v);
        r.out_w = row_dot(3, v);
        return r;
    endfunction

    function automatic t_word rand_word();
        logic [31:0] tmp;
        tmp = $urandom;
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3, 4, 5: return {{12{tmp[19]}}, tmp[19:0]};
            default: return tmp;
        endcase
    endfunction

    function automatic t_row rand_vertex();
        t_row v;
        foreach (v[i]) v[i] = rand_word();
        return v;
    endfunction

    task automatic push_load(input int r, input int c, input t_word val);
        t_vtx_txn t;
        t.kind  = KIND_LOAD;
        t.row   = r[IDX_W-1:0];
        t.col   = c[IDX_W-1:0];
        t.value = val;
        t.vtx   = rand_vertex();
        stim_q.push_back(t);
    endtask

    task automatic push_xform(input t_word x, input t_word y, input t_word z, input t_word w);
        t_vtx_txn t;
        t.kind   = KIND_XFORM;
        t.row    = IDX_W'($urandom);
        t.col    = IDX_W'($urandom);
        t.value  = $urandom;
        t.vtx[0] = x;
        t.vtx[1] = y;
        t.vtx[2] = z;
        t.vtx[3] = w;
        stim_q.push_back(t);
    endtask

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic wait_idle();
        while (stim_q.size() != 0 || in_bus.valid || vertex_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_took) begin
            if (stim_q.size() != 0 && (gaps_off || $urandom_range(0, 99) >= GAP_PCT)) begin
                nxt = stim_q.pop_front();
                in_bus.kind        <= nxt.kind;
                in_bus.entry_row   <= nxt.row;
                in_bus.entry_col   <= nxt.col;
                in_bus.entry_value <= nxt.value;
                in_bus.in_x        <= nxt.vtx[0];
                in_bus.in_y        <= nxt.vtx[1];
                in_bus.in_z        <= nxt.vtx[2];
                in_bus.in_w        <= nxt.vtx[3];
                in_bus.valid       <= 1'b1;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_bus.ready <= i_rst_n && (gaps_off || $urandom_range(0, 99) >= GAP_PCT);
    end

    always @(posedge i_clk) begin
        in_took <= i_rst_n && in_bus.valid && in_bus.ready;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            n_in <= n_in + 1;
            if (in_bus.kind == KIND_LOAD) begin
                matrix_words[{in_bus.entry_row, in_bus.entry_col}] = in_bus.entry_value;
            end else begin
                vertex_q.push_back(transform_vertex('{in_bus.in_x, in_bus.in_y,
                                                      in_bus.in_z, in_bus.in_w}));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = '{out_bus.out_x, out_bus.out_y, out_bus.out_z, out_bus.out_w};
            if (vertex_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
            end else begin
                want = vertex_q.pop_front();
                if (got.out_x !== want.out_x)
                    report($sformatf("out_x got %h want %h", got.out_x, want.out_x));
                if (got.out_y !== want.out_y)
                    report($sformatf("out_y got %h want %h", got.out_y, want.out_y));
                if (got.out_z !== want.out_z)
                    report($sformatf("out_z got %h want %h", got.out_z, want.out_z));
                if (got.out_w !== want.out_w)
                    report($sformatf("out_w got %h want %h", got.out_w, want.out_w));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL vertex_transform_4x4_top");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.kind        = KIND_LOAD;
        in_bus.entry_row   = '0;
        in_bus.entry_col   = '0;
        in_bus.entry_value = '0;
        in_bus.in_x        = '0;
        in_bus.in_y        = '0;
        in_bus.in_z        = '0;
        in_bus.in_w        = '0;
        out_bus.ready      = 1'b0;
        in_took            = 1'b0;
        n_in               = 0;
        n_errors           = 0;
        idle_cycles        = 0;
        for (int i = 0; i < DIM*DIM; i++) begin
            matrix_words[i] = (i / DIM == i % DIM) ? t_word'(1 << FRAC) : '0;
        end

        // identity pass-through of extremes
        push_xform(WORD_MAX, WORD_MIN, '0, -1);
        push_xform(rand_word(), rand_word(), rand_word(), rand_word());
        // row 0 all max, row 1 all min
        for (int c = 0; c < DIM; c++) push_load(0, c, WORD_MAX);
        for (int c = 0; c < DIM; c++) push_load(1, c, WORD_MIN);
        // row 2 distinct from row 0, row 3 one LSB in column 0
        push_load(2, 0, 32'sh0002_0000);
        push_load(2, 2, 32'shFFFF_0000);
        push_load(3, 0, 32'sh0000_0001);
        push_load(3, 3, '0);
        push_xform(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        push_xform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        push_xform(-1, -1, -1, -1);
        push_xform('0, '0, '0, '0);
        push_xform(32'sh0001_8000, 32'shFFFE_8000, 32'sh0000_0003, -3);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hold the sender until every vertex has come back
        wait_idle();
        for (int phase = 0; phase < 2; phase++) begin
            for (int i = 0; i < N_RANDOM / 2; i++) begin
                if ($urandom_range(0, 99) < 30) begin
                    push_load($urandom_range(0, 3), $urandom_range(0, 3), rand_word());
                end else begin
                    push_xform(rand_word(), rand_word(), rand_word(), rand_word());
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS vertex_transform_4x4_top");
        end else begin
            $display("FAIL vertex_transform_4x4_top");
        end
        $finish;
    end

endmodule

FILE: vertex_transform_4x4_top.f
+incdir+rtl
rtl/vtx_pkg.sv
rtl/vtx_in_if.sv
rtl/vtx_out_if.sv
rtl/vtx_lane.sv
rtl/vtx_merge.sv
rtl/vertex_transform_4x4_top.sv
rtl/vtx_checker.sv
test/tb_vertex_transform_4x4_top.sv
